[rtl/assert_macros.svh]
// assertion macros for the rtl modules, included by wbcs_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/wbcs_pkg.sv]
// shared types and constants of the white blob centroid steering block
`timescale 1ns / 1ps
package wbcs_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int WIDTH_W    = 13;
  localparam int COL_W      = 12;
  localparam int CNT_W      = 25;
  localparam int SUM_W      = 37;
  localparam int QUO_W      = 12;
  localparam int STEP_W     = 4;
  localparam int RECIP_W    = 17;

  localparam logic [7:0]         WHITE_LEVEL = 8'd255;
  localparam logic [CNT_W-1:0]   COUNT_CAP   = {CNT_W{1'b1}};
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 13'd4096;
  // ceil(2^17 / 3): x * this >> 17 is floor(x / 3) for x below 2^17
  localparam logic [RECIP_W-1:0] THIRD_RECIP = 17'd43691;

  // register index of the configuration port
  localparam logic REG_IMAGE_WIDTH = 1'b0;

  typedef enum logic [1:0] {
    CMD_STOP     = 2'd0,
    CMD_LEFT     = 2'd1,
    CMD_STRAIGHT = 2'd2,
    CMD_RIGHT    = 2'd3
  } steer_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } back_state_t;

  // per-frame totals handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0]   col_sum;
    logic [CNT_W-1:0]   count;
    logic [WIDTH_W-1:0] width;
  } frame_sum_t;

endpackage

[rtl/white_blob_centroid_steer_top.sv]
// top level of the white blob centroid steering block
`timescale 1ns / 1ps
// Takes one RGB pixel per cycle in raster order (push/full) and, on each pixel
// flagged in_frame_end, produces one result (pop/empty): steering command, floored
// mean column of pure-white pixels and their count. Pixels are accepted every
// cycle while the two-entry frame queue has room. Each frame's mean is worked out
// by a restoring divider at one quotient bit per cycle. For each frame the back end
// takes the frame totals, runs twelve quotient steps and loads the result register,
// waiting before the load while the result register still holds an unpopped
// result. It works on one frame while the next frame's pixels are accepted. Frames
// that arrive faster than the back end finishes them fill the queue, and full then
// holds the input off until the back end frees an entry.
// image_width lies at byte address 0 of the APB port and resets to 640.
module white_blob_centroid_steer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel input
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  input  logic                         in_frame_end,
  // result output
  input  logic                         pop,
  output logic                         empty,
  output logic [1:0]                   out_steer_command,
  output logic [wbcs_pkg::QUO_W-1:0]   out_mean_column,
  output logic [wbcs_pkg::CNT_W-1:0]   out_white_total,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [wbcs_pkg::WIDTH_W-1:0] width_r;
  logic                         cfg_wr;
  logic                         in_accept;
  logic                         f_push;
  wbcs_pkg::frame_sum_t         f_sum, q_data;
  logic                         q_full, q_empty, q_pop;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= wbcs_pkg::WIDTH_RESET;
    end else if (cfg_wr && paddr[2] == wbcs_pkg::REG_IMAGE_WIDTH) begin
      width_r <= pwdata[wbcs_pkg::WIDTH_W-1:0];
    end
  end

  assign prdata = (paddr[2] == wbcs_pkg::REG_IMAGE_WIDTH) ?
                  {{(32-wbcs_pkg::WIDTH_W){1'b0}}, width_r} : '0;

  // input handshake
  assign full      = q_full;
  assign in_accept = push && !q_full;

  wbcs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept_i      (in_accept),
    .red_i         (in_red),
    .green_i       (in_green),
    .blue_i        (in_blue),
    .frame_end_i   (in_frame_end),
    .image_width_i (width_r),
    .push_o        (f_push),
    .sum_o         (f_sum)
  );

  wbcs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .data_i  (f_sum),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  wbcs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty_i       (q_empty),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .steer_command_o (out_steer_command),
    .mean_column_o   (out_mean_column),
    .white_total_o   (out_white_total)
  );

endmodule

[rtl/wbcs_front.sv]
// pixel front end: white test, column tracking and per-frame accumulation
`timescale 1ns / 1ps
module wbcs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic                          frame_end_i,
  input  logic [wbcs_pkg::WIDTH_W-1:0]  image_width_i,
  output logic                          push_o,
  output wbcs_pkg::frame_sum_t          sum_o
);

  logic [wbcs_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [wbcs_pkg::CNT_W-1:0]   count_r, count_nxt, count_upd;
  logic [wbcs_pkg::SUM_W-1:0]   sum_r, sum_nxt, sum_upd;
  logic [wbcs_pkg::WIDTH_W-1:0] w_eff;
  logic [wbcs_pkg::WIDTH_W-1:0] col_inc;
  logic                         is_white;

  // width clamped to 1..MAX_WIDTH
  always_comb begin
    if (image_width_i == '0) begin
      w_eff = wbcs_pkg::WIDTH_W'(1);
    end else if (image_width_i > wbcs_pkg::WIDTH_MAX) begin
      w_eff = wbcs_pkg::WIDTH_MAX;
    end else begin
      w_eff = image_width_i;
    end
  end

  // white test, saturated count stops accumulation
  assign is_white = (red_i == wbcs_pkg::WHITE_LEVEL) && (green_i == wbcs_pkg::WHITE_LEVEL) &&
                    (blue_i == wbcs_pkg::WHITE_LEVEL) && (count_r != wbcs_pkg::COUNT_CAP);

  assign count_upd = is_white ? count_r + 1'b1 : count_r;
  assign sum_upd   = is_white ? sum_r + {{(wbcs_pkg::SUM_W-wbcs_pkg::COL_W){1'b0}}, col_r}
                              : sum_r;
  assign col_inc   = {1'b0, col_r} + 1'b1;

  // next accumulator state per accepted pixel
  always_comb begin
    col_nxt   = col_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    push_o    = 1'b0;
    if (accept_i) begin
      if (frame_end_i) begin
        push_o    = 1'b1;
        col_nxt   = '0;
        count_nxt = '0;
        sum_nxt   = '0;
      end else begin
        count_nxt = count_upd;
        sum_nxt   = sum_upd;
        col_nxt   = (col_inc >= w_eff) ? '0 : col_inc[wbcs_pkg::COL_W-1:0];
      end
    end
  end

  // frame totals including the last pixel
  assign sum_o.col_sum = sum_upd;
  assign sum_o.count   = count_upd;
  assign sum_o.width   = w_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      col_r   <= col_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

[rtl/wbcs_queue.sv]
// two-entry queue of frame totals between front and back
`timescale 1ns / 1ps
module wbcs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  wbcs_pkg::frame_sum_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output wbcs_pkg::frame_sum_t data_o
);

  wbcs_pkg::frame_sum_t mem_r [2];
  logic                 wr_ptr_r, rd_ptr_r;
  logic [1:0]           cnt_r;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_r == 2'd2);
  assign empty_o = (cnt_r == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/wbcs_back.sv]
// back end: mean column by restoring division, steering decision, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wbcs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty_i,
  input  wbcs_pkg::frame_sum_t          q_data_i,
  output logic                          q_pop_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [1:0]                    steer_command_o,
  output logic [wbcs_pkg::QUO_W-1:0]    mean_column_o,
  output logic [wbcs_pkg::CNT_W-1:0]    white_total_o
);

  localparam int PROD_W = wbcs_pkg::WIDTH_W + 1 + wbcs_pkg::RECIP_W;

  wbcs_pkg::back_state_t state_r, state_nxt;

  logic [wbcs_pkg::SUM_W-1:0]   rem_r, rem_nxt;
  logic [wbcs_pkg::SUM_W-1:0]   div_r, div_nxt;
  logic [wbcs_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [wbcs_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [wbcs_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [wbcs_pkg::WIDTH_W-1:0] w_r, w_nxt;
  logic [wbcs_pkg::WIDTH_W-1:0] third_r, two_third_r;
  logic [PROD_W-1:0]            third_prod, two_third_prod;
  logic                         ge;

  logic                         out_valid_r, out_valid_nxt;
  wbcs_pkg::steer_cmd_t         cmd_r, cmd_nxt;
  logic [wbcs_pkg::QUO_W-1:0]   mean_r, mean_nxt;
  logic [wbcs_pkg::CNT_W-1:0]   total_r, total_nxt;
  wbcs_pkg::steer_cmd_t         cmd_calc;

  // thirds of the width by reciprocal multiply
  assign third_prod     = {1'b0, w_r} * wbcs_pkg::THIRD_RECIP;
  assign two_third_prod = {w_r, 1'b0} * wbcs_pkg::THIRD_RECIP;

  always_ff @(posedge clk) begin
    third_r     <= third_prod[wbcs_pkg::RECIP_W +: wbcs_pkg::WIDTH_W];
    two_third_r <= two_third_prod[wbcs_pkg::RECIP_W +: wbcs_pkg::WIDTH_W];
  end

  // one quotient bit per cycle
  assign ge = (rem_r >= div_r) && (count_r != '0);

  // steering decision from finished quotient
  always_comb begin
    if (count_r == '0) begin
      cmd_calc = wbcs_pkg::CMD_STOP;
    end else if ({1'b0, quo_r} < third_r) begin
      cmd_calc = wbcs_pkg::CMD_LEFT;
    end else if ({1'b0, quo_r} > two_third_r) begin
      cmd_calc = wbcs_pkg::CMD_RIGHT;
    end else begin
      cmd_calc = wbcs_pkg::CMD_STRAIGHT;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    w_nxt         = w_r;
    q_pop_o       = 1'b0;
    out_valid_nxt = out_valid_r && !pop_i;
    cmd_nxt       = cmd_r;
    mean_nxt      = mean_r;
    total_nxt     = total_r;
    unique case (state_r)
      wbcs_pkg::S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          rem_nxt   = q_data_i.col_sum;
          div_nxt   = {1'b0, q_data_i.count, {(wbcs_pkg::QUO_W-1){1'b0}}};
          quo_nxt   = '0;
          step_nxt  = wbcs_pkg::STEP_W'(wbcs_pkg::QUO_W - 1);
          count_nxt = q_data_i.count;
          w_nxt     = q_data_i.width;
          state_nxt = wbcs_pkg::S_DIV;
        end
      end
      wbcs_pkg::S_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - div_r;
        end
        quo_nxt  = {quo_r[wbcs_pkg::QUO_W-2:0], ge};
        div_nxt  = div_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = wbcs_pkg::S_DONE;
        end
      end
      wbcs_pkg::S_DONE: begin
        if (!out_valid_r || pop_i) begin
          out_valid_nxt = 1'b1;
          cmd_nxt       = cmd_calc;
          mean_nxt      = (count_r == '0) ? '0 : quo_r;
          total_nxt     = count_r;
          state_nxt     = wbcs_pkg::S_IDLE;
        end
      end
      default: state_nxt = wbcs_pkg::S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    quo_r   <= quo_nxt;
    step_r  <= step_nxt;
    count_r <= count_nxt;
    w_r     <= w_nxt;
    cmd_r   <= cmd_nxt;
    mean_r  <= mean_nxt;
    total_r <= total_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wbcs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty_o         = !out_valid_r;
  assign steer_command_o = cmd_r;
  assign mean_column_o   = mean_r;
  assign white_total_o   = total_r;

  // checks
  `ASSERT_RST(a_stop_zero, clk, rst_n, (out_valid_r && cmd_r == wbcs_pkg::CMD_STOP |-> mean_r == '0 && total_r == '0), "stop result carries nonzero mean or count")
  `ASSERT_RST(a_go_nonzero, clk, rst_n, (out_valid_r && cmd_r != wbcs_pkg::CMD_STOP |-> total_r != '0), "steering result without white pixels")
  `ASSERT_RST(a_div_len, clk, rst_n, (state_r == wbcs_pkg::S_DIV && step_r == '0 |=> state_r == wbcs_pkg::S_DONE), "division did not finish after last step")
  `ASSERT_ALWAYS(a_reset_idle, clk, (!rst_n |=> state_r == wbcs_pkg::S_IDLE && !out_valid_r), "reset did not clear back end")

endmodule
